FILE: src/tsc_pkg.sv
package tsc_pkg;

  localparam int TSC_TERMS = 16;

  localparam logic signed [30:0] PI_Q28 = 31'sd843314857;
  localparam logic signed [30:0] NEG_PI_Q28 = -31'sd843314857;
  localparam logic [29:0] PI_MAG = 30'd843314857;
  localparam logic [62:0] MAG_LIMIT = 63'h4000_0000_0000_0000;

  // Successive floor divisions give floor(2^62 / n!) exactly.
  localparam logic [63:0] Q1 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] Q2 = Q1 / 64'd2;
  localparam logic [63:0] Q3 = Q2 / 64'd3;
  localparam logic [63:0] Q4 = Q3 / 64'd4;
  localparam logic [63:0] Q5 = Q4 / 64'd5;
  localparam logic [63:0] Q6 = Q5 / 64'd6;
  localparam logic [63:0] Q7 = Q6 / 64'd7;
  localparam logic [63:0] Q8 = Q7 / 64'd8;
  localparam logic [63:0] Q9 = Q8 / 64'd9;
  localparam logic [63:0] Q10 = Q9 / 64'd10;
  localparam logic [63:0] Q11 = Q10 / 64'd11;
  localparam logic [63:0] Q12 = Q11 / 64'd12;
  localparam logic [63:0] Q13 = Q12 / 64'd13;
  localparam logic [63:0] Q14 = Q13 / 64'd14;
  localparam logic [63:0] Q15 = Q14 / 64'd15;
  localparam logic [63:0] Q16 = Q15 / 64'd16;
  localparam logic [63:0] Q17 = Q16 / 64'd17;
  localparam logic [63:0] Q18 = Q17 / 64'd18;
  localparam logic [63:0] Q19 = Q18 / 64'd19;
  localparam logic [63:0] Q20 = Q19 / 64'd20;
  localparam logic [63:0] Q21 = Q20 / 64'd21;
  localparam logic [63:0] Q22 = Q21 / 64'd22;
  localparam logic [63:0] Q23 = Q22 / 64'd23;
  localparam logic [63:0] Q24 = Q23 / 64'd24;
  localparam logic [63:0] Q25 = Q24 / 64'd25;
  localparam logic [63:0] Q26 = Q25 / 64'd26;
  localparam logic [63:0] Q27 = Q26 / 64'd27;
  localparam logic [63:0] Q28 = Q27 / 64'd28;
  localparam logic [63:0] Q29 = Q28 / 64'd29;
  localparam logic [63:0] Q30 = Q29 / 64'd30;
  localparam logic [63:0] Q31 = Q30 / 64'd31;
  localparam logic [63:0] Q32 = Q31 / 64'd32;
  localparam logic [63:0] Q33 = Q32 / 64'd33;

  localparam logic [63:0] QTAB [0:33] = '{
    Q1, Q1, Q2, Q3, Q4, Q5, Q6, Q7, Q8, Q9, Q10, Q11, Q12, Q13, Q14, Q15, Q16,
    Q17, Q18, Q19, Q20, Q21, Q22, Q23, Q24, Q25, Q26, Q27, Q28, Q29, Q30, Q31,
    Q32, Q33
  };

  // Magnitude of 1/n! in Q.61, rounded half up.
  function automatic logic [61:0] coef_mag(input logic [5:0] n);
    logic [63:0] q;
    begin
      q = QTAB[n] + 64'd1;
      return q[62:1];
    end
  endfunction

  typedef struct packed {
    logic        opcode;
    logic        xsgn;
    logic [29:0] xmag;
    logic [61:0] x2;
    logic        psgn;
    logic [62:0] pmag;
  } tsc_item_t;

endpackage

FILE: src/taylor_sine_cosine_top.sv
// Channel   Valid      Stall      Payload
// request   req_valid  req_stall  opcode, angle
// result    res_valid  res_stall  value
//
// One request enters per cycle while req_stall is low; each result passes through two input
// stages, three stages per Horner term and three output stages.
// Each Horner stage group splits its 63x62-bit product into four partial products of at most 32x32 bits.
// Reset clears the valid bits of all stages; data registers are not reset.
// A stalled result holds in the output register while earlier stages keep closing bubbles;
// req_stall rises only when every stage ahead of the input register is full.
module taylor_sine_cosine_top #(
  parameter int TERMS = tsc_pkg::TSC_TERMS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               opcode,
  input  logic signed [30:0] angle,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] value
);
  import tsc_pkg::*;

  localparam logic [61:0] COS_INIT = coef_mag(6'(2 * TERMS));
  localparam logic [61:0] SIN_INIT = coef_mag(6'(2 * TERMS + 1));
  localparam logic INIT_NEG = 1'(TERMS % 2);

  logic        s1_valid, s2_valid, f1_valid, f2_valid, f3_valid;
  logic        en1, en2, en_f1, en_f2, en_f3;
  logic        s1_opcode, s1_xsgn;
  logic [29:0] s1_xmag;
  logic [29:0] xmag_next;
  logic signed [30:0] neg_angle;
  tsc_item_t   s2_item;

  tsc_item_t chain_item [0:TERMS];
  logic      chain_valid [0:TERMS];
  logic      chain_stall [0:TERMS];

  logic [61:0] f1_lo;
  logic [60:0] f1_hi;
  logic [62:0] f1_pmag;
  logic        f1_neg, f1_sine;
  logic [93:0] full_s;
  logic [63:0] full_c;
  logic [34:0] f2_mag_next;
  logic [34:0] f2_mag;
  logic        f2_neg;
  logic [31:0] f3_value_next;
  logic [31:0] f3_value;
  tsc_item_t   last_item;

  assign en_f3 = ~f3_valid | ~res_stall;
  assign en_f2 = ~f2_valid | en_f3;
  assign en_f1 = ~f1_valid | en_f2;
  assign en2 = ~s2_valid | ~chain_stall[0];
  assign en1 = ~s1_valid | en2;
  assign req_stall = ~en1;
  assign res_valid = f3_valid;
  assign value = signed'(f3_value);

  always_comb begin
    neg_angle = -angle;
    if (!angle[30]) begin
      xmag_next = (angle > PI_Q28) ? PI_MAG : angle[29:0];
    end else begin
      xmag_next = (angle < NEG_PI_Q28) ? PI_MAG : neg_angle[29:0];
    end
  end

  assign chain_valid[0] = s2_valid;
  assign chain_item[0] = s2_item;
  assign chain_stall[TERMS] = ~en_f1;
  assign last_item = chain_item[TERMS];

  for (genvar i = 0; i < TERMS; i++) begin : g_step
    tsc_step #(
      .K(TERMS - 1 - i)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_stall (chain_stall[i]),
      .up_item  (chain_item[i]),
      .dn_valid (chain_valid[i + 1]),
      .dn_stall (chain_stall[i + 1]),
      .dn_item  (chain_item[i + 1])
    );
  end

  always_comb begin
    full_s = 94'(f1_lo) + (94'(f1_hi) << 32) + (94'(1) << 58);
    full_c = 64'(f1_pmag) + (64'(1) << 30);
    f2_mag_next = f1_sine ? full_s[93:59] : 35'(full_c[63:31]);
  end

  always_comb begin
    if (!f2_neg) begin
      f3_value_next = (f2_mag > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : f2_mag[31:0];
    end else begin
      f3_value_next = (f2_mag >= 35'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - f2_mag[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= req_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en_f1) begin
        f1_valid <= chain_valid[TERMS];
      end
      if (en_f2) begin
        f2_valid <= f1_valid;
      end
      if (en_f3) begin
        f3_valid <= f2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && req_valid) begin
      s1_opcode <= opcode;
      s1_xsgn <= angle[30];
      s1_xmag <= xmag_next;
    end
    if (en2 && s1_valid) begin
      s2_item.opcode <= s1_opcode;
      s2_item.xsgn <= s1_xsgn;
      s2_item.xmag <= s1_xmag;
      s2_item.x2 <= {60'(s1_xmag) * 60'(s1_xmag), 2'b00};
      s2_item.psgn <= INIT_NEG;
      s2_item.pmag <= {1'b0, (s1_opcode ? SIN_INIT : COS_INIT)};
    end
    if (en_f1 && chain_valid[TERMS]) begin
      f1_lo <= 62'(last_item.pmag[31:0]) * 62'(last_item.xmag);
      f1_hi <= 61'(last_item.pmag[62:32]) * 61'(last_item.xmag);
      f1_pmag <= last_item.pmag;
      f1_sine <= last_item.opcode;
      f1_neg <= last_item.opcode ? (last_item.psgn ^ last_item.xsgn) : last_item.psgn;
    end
    if (en_f2 && f1_valid) begin
      f2_mag <= f2_mag_next;
      f2_neg <= f1_neg;
    end
    if (en_f3 && f2_valid) begin
      f3_value <= f3_value_next;
    end
  end

`ifndef SYNTH
  a_reset_clears_output: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");
  a_stall_needs_full_input: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid)
    else $error("request stalled with an empty input stage");
  a_empty_output_never_stalls: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !req_stall)
    else $error("request stalled while the output register is empty");
`endif

endmodule

FILE: src/tsc_step.sv
module tsc_step #(
  parameter int K = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_stall,
  input  tsc_pkg::tsc_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_stall,
  output tsc_pkg::tsc_item_t dn_item
);
  import tsc_pkg::*;

  localparam logic [61:0] COS_MAG = coef_mag(6'(2 * K));
  localparam logic [61:0] SIN_MAG = coef_mag(6'(2 * K + 1));
  localparam logic COEF_NEG = 1'(K % 2);

  logic      a_valid, b_valid, c_valid;
  logic      en_a, en_b, en_c;
  tsc_item_t a_item, b_item, c_item;
  logic [63:0] a_ll;
  logic [61:0] a_lh;
  logic [62:0] a_hl;
  logic [60:0] a_hh;
  logic        b_sgn;
  logic [62:0] b_mag;

  logic [124:0] b_full;
  logic [66:0]  b_shift;
  logic [62:0]  b_mag_next;

  logic [61:0]        c_cmag;
  logic signed [64:0] c_pos, c_coef, c_ms, c_sum, c_nsum;
  tsc_item_t          c_item_next;

  assign en_c = ~c_valid | ~dn_stall;
  assign en_b = ~b_valid | en_c;
  assign en_a = ~a_valid | en_b;
  assign up_stall = ~en_a;
  assign dn_valid = c_valid;
  assign dn_item = c_item;

  always_comb begin
    b_full = 125'(a_ll) + (125'(a_lh) << 32) + (125'(a_hl) << 32) + (125'(a_hh) << 64)
           + (125'(1) << 57);
    b_shift = b_full[124:58];
    b_mag_next = (b_shift > 67'(MAG_LIMIT)) ? MAG_LIMIT : b_shift[62:0];
  end

  always_comb begin
    c_cmag = b_item.opcode ? SIN_MAG : COS_MAG;
    c_pos = signed'({3'b000, c_cmag});
    c_coef = COEF_NEG ? -c_pos : c_pos;
    c_ms = signed'({2'b00, b_mag});
    c_sum = b_sgn ? (c_coef - c_ms) : (c_coef + c_ms);
    c_nsum = b_sgn ? (c_ms - c_coef) : (-c_coef - c_ms);
    c_item_next = b_item;
    c_item_next.psgn = c_sum[64];
    c_item_next.pmag = c_sum[64] ? c_nsum[62:0] : c_sum[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= up_valid;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
      if (en_c) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && up_valid) begin
      a_item <= up_item;
      a_ll <= 64'(up_item.pmag[31:0]) * 64'(up_item.x2[31:0]);
      a_lh <= 62'(up_item.pmag[31:0]) * 62'(up_item.x2[61:32]);
      a_hl <= 63'(up_item.pmag[62:32]) * 63'(up_item.x2[31:0]);
      a_hh <= 61'(up_item.pmag[62:32]) * 61'(up_item.x2[61:32]);
    end
    if (en_b && a_valid) begin
      b_item <= a_item;
      b_sgn <= a_item.psgn;
      b_mag <= b_mag_next;
    end
    if (en_c && b_valid) begin
      c_item <= c_item_next;
    end
  end

endmodule

FILE: tb/taylor_sine_cosine_top_tb.sv
`timescale 1ns / 100ps

module taylor_sine_cosine_top_tb;

  localparam int TERMS = tsc_pkg::TSC_TERMS;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 3 * TERMS + 12;
  localparam int HOLD_OFF = 400;
  localparam int MAX_PRINTS = 40;
  localparam logic OP_COS = 1'b0;
  localparam logic OP_SIN = 1'b1;

  typedef struct {
    logic               op;
    logic signed [30:0] ang;
    logic signed [31:0] val;
  } trig_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               opcode = 1'b0;
  logic signed [30:0] angle = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic signed [31:0] value;

  trig_req_t pending_results[$];
  trig_req_t head;
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  int        send_gap_max = 0;
  int        recv_gap_max = 0;
  int        hold_off_cycles = 0;

  taylor_sine_cosine_top #(.TERMS(TERMS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .opcode    (opcode),
    .angle     (angle),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value     (value)
  );

  always #1 clk = ~clk;

  // Product a*b shifted right by sh, rounded to nearest with ties away from zero,
  // with its magnitude limited to 2^62.
  function automatic longint signed round_mul(input longint signed a, input longint signed b,
                                              input int unsigned sh);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] prod;
    logic [127:0] q;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    prod = 128'(ua) * 128'(ub);
    q = (prod + (128'd1 << (sh - 1))) >> sh;
    if (q > (128'd1 << 62)) q = 128'd1 << 62;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // Signed Q.61 coefficient of term k: 1/(2k)! for cosine, 1/(2k+1)! for sine.
  function automatic longint signed series_coef(input int k, input logic op);
    logic [63:0] q;
    int          n;
    int          i;
    n = 2 * k + int'(op);
    q = 64'h4000_0000_0000_0000;
    for (i = 2; i <= n; i++) q = q / 64'(i);
    q = (q + 64'd1) >> 1;
    return k[0] ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] sincos_value(input logic op,
                                                      input logic signed [30:0] ang);
    longint signed x;
    longint signed x2;
    longint signed p;
    longint signed v;
    int            k;
    x = longint'(ang);
    if (x > longint'(tsc_pkg::PI_Q28)) x = longint'(tsc_pkg::PI_Q28);
    if (x < longint'(tsc_pkg::NEG_PI_Q28)) x = longint'(tsc_pkg::NEG_PI_Q28);
    x2 = x * x * 4;
    p = series_coef(TERMS, op);
    for (k = TERMS; k > 0; k--) p = series_coef(k - 1, op) + round_mul(p, x2, 58);
    v = (op == OP_SIN) ? round_mul(p, x, 59) : round_mul(p, 1, 31);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic flag_error(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_request(input logic op, input logic signed [30:0] ang);
    int        gap;
    trig_req_t item;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode <= op;
    angle <= ang;
    do @(posedge clk); while (req_stall);
    item.op = op;
    item.ang = ang;
    item.val = sincos_value(op, ang);
    pending_results.push_back(item);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [30:0] draw_angle();
    int r;
    case ($urandom_range(9, 0))
      0: return 31'($urandom());
      1: begin
        r = 843314857 + int'($urandom_range(64, 0)) - 32;
        return ($urandom_range(1, 0) != 0) ? 31'(r) : 31'(-r);
      end
      default: begin
        r = int'($urandom_range(1686629714, 0)) - 843314857;
        return 31'(r);
      end
    endcase
  endfunction

  function automatic int draw_gap_max();
    case ($urandom_range(2, 0))
      0: return 0;
      1: return 2;
      default: return 16;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [30:0] angles [11];
    int                 i;
    angles = '{31'sd0, tsc_pkg::PI_Q28, tsc_pkg::NEG_PI_Q28, tsc_pkg::PI_Q28 + 31'sd1,
               tsc_pkg::NEG_PI_Q28 - 31'sd1, 31'sh3FFFFFFF, 31'sh40000000, 31'sd1, -31'sd1,
               31'sd421657428, -31'sd421657428};
    send_gap_max = 3;
    recv_gap_max = 3;
    for (i = 0; i < 11; i++) begin
      send_request(OP_COS, angles[i]);
      send_request(OP_SIN, angles[i]);
    end
    req_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    int i;
    for (i = 0; i < 1130; i++) begin
      if (i % 64 == 0) begin
        send_gap_max = draw_gap_max();
        recv_gap_max = draw_gap_max();
      end
      send_request(1'($urandom_range(1, 0)), draw_angle());
    end
    req_valid <= 1'b0;
    wait_drained();
  endtask

  // The receiver holds off while requests keep coming, so the pipeline fills and
  // the block must stall its request channel.
  task automatic test_pressure();
    int i;
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_off_cycles = HOLD_OFF;
    for (i = 0; i < 150; i++) send_request(1'($urandom_range(1, 0)), draw_angle());
    req_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin : result_receiver
    int n;
    wait (rst == 1'b0);
    forever begin
      if (hold_off_cycles > 0) begin
        res_stall <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      n = $urandom_range(recv_gap_max, 0);
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no request pending", value));
      end else begin
        head = pending_results.pop_front();
        if (value !== head.val) begin
          flag_error($sformatf("opcode %0d angle %0d: value %0d, expected %0d",
                               head.op, head.ang, value, head.val));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without progress.", IDLE_LIMIT);
      $display("taylor_sine_cosine_top_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_pressure();
    if (mismatch_count == 0) begin
      $display("taylor_sine_cosine_top_tb: PASS");
    end else begin
      $display("taylor_sine_cosine_top_tb: FAIL");
    end
    $finish;
  end

endmodule
